// ----- rtl/kce_pkg.sv -----
// Shared constants, codes and interface types of the k-gram count block.
`default_nettype none
package kce_pkg;

	localparam int TABLE_DEPTH = 65536;
	localparam int COUNT_WIDTH = 16;

	localparam int ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SPAN_W    = ADDR_W + 1;
	localparam int DIV_W     = ADDR_W + 5;
	localparam int FWD_STEPS = 4;
	localparam int DIV_KMAX  = (ADDR_W > FWD_STEPS) ? ADDR_W : FWD_STEPS;
	localparam int DIV_KW    = $clog2(DIV_KMAX + 1);
	localparam int DIV_SHW   = $clog2(DIV_W + 1);
	localparam int REG_W     = 5;

	localparam logic [REG_W-1:0] BASE_MIN  = 5'd2;
	localparam logic [REG_W-1:0] BASE_MAX  = 5'd16;
	localparam logic [REG_W-1:0] LEN_MIN   = 5'd1;
	localparam logic [REG_W-1:0] LEN_MAX   = 5'd16;
	localparam logic [REG_W-1:0] BASE_RST  = 5'd2;
	localparam logic [REG_W-1:0] LEN_RST   = 5'd1;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_LEN  = 1'b1;

	localparam logic [1:0] MODE_FWD   = 2'd0;
	localparam logic [1:0] MODE_SCAN  = 2'd1;
	localparam logic [1:0] MODE_BWD   = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SAT       = 2'd1;
	localparam logic [1:0] ST_BAD_CFG   = 2'd2;
	localparam logic [1:0] ST_BAD_DIGIT = 2'd3;

	typedef struct packed {
		logic [REG_W-1:0]  base;
		logic [REG_W-1:0]  length;
		logic [SPAN_W-1:0] span;
		logic              busy;
	} cfg_t;

	typedef struct packed {
		logic       latch_in;
		logic       clr_regs;
		logic       clr_init;
		logic       clr_wr;
		logic       div_red;
		logic       div_fwd;
		logic       div_bwd;
		logic       take_red;
		logic       take_fwd;
		logic       take_bwd;
		logic       seen_inc;
		logic       seen_full;
		logic       rd_win;
		logic       upd_fwd;
		logic       upd_bwd;
		logic       scan_init;
		logic       scan_rd;
		logic       scan_fin;
		logic       res_set;
		logic [1:0] res_st;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       digit_bad;
		logic       span_zero;
		logic       win_ge_span;
		logic       seen_short_fwd;
		logic       seen_short_bwd;
		logic       div_busy;
		logic       clr_last;
		logic       scan_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/kgram_count_extremes.sv -----
// Top level of the k-gram window counter with running count extremes.
//
// Each item carries a mode and a digit and yields one result item. A forward digit
// and a backward digit each run the one-bit-per-cycle divider (4 steps forward,
// ADDR_W steps backward for the division by the base) and a table read-modify-write.
// When the window is not below the span, as after a register write, an item other
// than a clear first reduces the window by the new span in ADDR_W divider steps.
// A minimum scan reads the table entries below the span, one table read per cycle.
// A clear writes every table entry, one table entry written per cycle. After reset
// the same clearing pass runs before the first item is taken. A register write
// recomputes the span iteratively, during which no item is taken. A finished result
// waits in the output register while the next item is taken.
`default_nettype none
module kgram_count_extremes (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [3:0] digit, [7:4] zero
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] count_value, [31:16] witness
	output logic [1:0]       m_tuser,   // [1:0] status
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	kce_pkg::cfg_t cfg;
	kce_pkg::cmd_t cmd;
	kce_pkg::sts_t sts;
	logic [15:0]   count_value;
	logic [15:0]   witness;

	kce_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.span_busy (cfg.busy),
		.sts       (sts),
		.cmd       (cmd)
	);

	kce_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.in_mode     (s_tuser),
		.in_digit    (s_tdata[3:0]),
		.sts         (sts),
		.count_value (count_value),
		.witness     (witness),
		.status      (m_tuser)
	);

	assign m_tdata = {witness, count_value};

endmodule
`default_nettype wire

// ----- rtl/kce_div.sv -----
// Restoring divider, one quotient bit per cycle, for a caller-given bit count.
`default_nettype none
module kce_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [kce_pkg::DIV_W-1:0]  dividend,
	input  wire logic [kce_pkg::SPAN_W-1:0] divisor,
	input  wire logic [kce_pkg::DIV_KW-1:0] steps,
	output logic                            busy,
	output logic [kce_pkg::DIV_W-1:0]       quot,
	output logic [kce_pkg::SPAN_W-1:0]      rem
);

	logic                          busy_q;
	logic [kce_pkg::DIV_KW-1:0]    cnt_q;
	logic [kce_pkg::SPAN_W-1:0]    r_q;
	logic [kce_pkg::SPAN_W-1:0]    d_q;
	logic [kce_pkg::DIV_W-1:0]     q_q;
	logic [kce_pkg::DIV_SHW-1:0]   lsh;
	logic [kce_pkg::SPAN_W:0]      trial;
	logic [kce_pkg::SPAN_W:0]      diff;
	logic                          ge;

	assign lsh   = kce_pkg::DIV_SHW'(kce_pkg::DIV_W) - kce_pkg::DIV_SHW'(steps);
	assign trial = {r_q, q_q[kce_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - kce_pkg::DIV_KW'(1);
			if (cnt_q == kce_pkg::DIV_KW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= kce_pkg::SPAN_W'(dividend >> steps);
			q_q <= dividend << lsh;
			d_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff[kce_pkg::SPAN_W-1:0] : trial[kce_pkg::SPAN_W-1:0];
			q_q <= {q_q[kce_pkg::DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule
`default_nettype wire

// ----- rtl/kce_cfg.sv -----
// Register port and iterative table span computation.
`default_nettype none
module kce_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output kce_pkg::cfg_t    cfg
);

	logic [kce_pkg::REG_W-1:0]    base_q;
	logic [kce_pkg::REG_W-1:0]    len_q;
	logic [kce_pkg::SPAN_W-1:0]   span_q;
	logic [kce_pkg::SPAN_W-1:0]   p_q;
	logic [kce_pkg::REG_W-1:0]    cnt_q;
	logic                         busy_q;
	logic                         wr;
	logic                         idx;
	logic [kce_pkg::REG_W-1:0]    nb;
	logic [kce_pkg::REG_W-1:0]    nl;
	logic                         ok;
	logic [kce_pkg::SPAN_W+4:0]   prod;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[2];
	assign nb  = (idx == kce_pkg::REG_BASE) ? pwdata[kce_pkg::REG_W-1:0] : base_q;
	assign nl  = (idx == kce_pkg::REG_LEN) ? pwdata[kce_pkg::REG_W-1:0] : len_q;
	assign ok  = (nb >= kce_pkg::BASE_MIN) && (nb <= kce_pkg::BASE_MAX)
		&& (nl >= kce_pkg::LEN_MIN) && (nl <= kce_pkg::LEN_MAX);
	assign prod = (kce_pkg::SPAN_W+5)'(p_q) * (kce_pkg::SPAN_W+5)'(base_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= kce_pkg::BASE_RST;
			len_q  <= kce_pkg::LEN_RST;
			span_q <= kce_pkg::SPAN_W'(2);
			busy_q <= 1'b0;
			cnt_q  <= '0;
			p_q    <= '0;
		end else if (wr) begin
			base_q <= nb;
			len_q  <= nl;
			cnt_q  <= '0;
			p_q    <= kce_pkg::SPAN_W'(1);
			busy_q <= ok;
			if (!ok) begin
				span_q <= '0;
			end
		end else if (busy_q) begin
			if (prod > (kce_pkg::SPAN_W+5)'(kce_pkg::TABLE_DEPTH)) begin
				span_q <= '0;
				busy_q <= 1'b0;
			end else if (cnt_q + kce_pkg::REG_W'(1) == len_q) begin
				span_q <= prod[kce_pkg::SPAN_W-1:0];
				busy_q <= 1'b0;
			end else begin
				p_q   <= prod[kce_pkg::SPAN_W-1:0];
				cnt_q <= cnt_q + kce_pkg::REG_W'(1);
			end
		end
	end

	always_comb begin
		unique case (idx)
			kce_pkg::REG_BASE: prdata = 32'(base_q);
			kce_pkg::REG_LEN:  prdata = 32'(len_q);
			default:           prdata = '0;
		endcase
	end

	assign pready     = 1'b1;
	assign cfg.base   = base_q;
	assign cfg.length = len_q;
	assign cfg.span   = span_q;
	assign cfg.busy   = busy_q;

endmodule
`default_nettype wire

// ----- rtl/kce_dpath.sv -----
// Datapath: count table, window state, running extremes, divider and result registers.
`default_nettype none
module kce_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kce_pkg::cmd_t cmd,
	input  wire kce_pkg::cfg_t cfg,
	input  wire logic [1:0]    in_mode,
	input  wire logic [3:0]    in_digit,
	output kce_pkg::sts_t      sts,
	output logic [15:0]        count_value,
	output logic [15:0]        witness,
	output logic [1:0]         status
);

	localparam int AW = kce_pkg::ADDR_W;
	localparam int CW = kce_pkg::COUNT_WIDTH;

	logic [CW-1:0]              mem [kce_pkg::TABLE_DEPTH];
	logic [CW-1:0]              rdata_q;

	logic [1:0]                 mode_q;
	logic [3:0]                 digit_q;
	logic [AW-1:0]              w_q;
	logic [kce_pkg::REG_W-1:0]  seen_q;
	logic [CW-1:0]              best_max_q;
	logic [AW-1:0]              max_wit_q;
	logic [CW-1:0]              best_min_q;
	logic [AW-1:0]              min_wit_q;
	logic [AW-1:0]              clr_q;
	logic [kce_pkg::SPAN_W-1:0] scan_q;
	logic                       scan_v_s1;
	logic [AW-1:0]              scan_addr_s1;
	logic [CW-1:0]              scan_mn_q;
	logic [AW-1:0]              scan_wt_q;
	logic [CW-1:0]              res_cnt_q;
	logic [AW-1:0]              res_wit_q;
	logic [1:0]                 res_st_q;
	logic [15:0]                out_cnt_q;
	logic [15:0]                out_wit_q;
	logic [1:0]                 out_st_q;

	logic                       inc_sat;
	logic                       dec_sat;
	logic [CW-1:0]              nc_fwd;
	logic [CW-1:0]              nc_bwd;
	logic                       f_gt;
	logic                       f_tie;
	logic                       b_lt;
	logic                       b_tie;
	logic [CW-1:0]              nbm;
	logic [AW-1:0]              nmw;
	logic [CW-1:0]              nbn;
	logic [AW-1:0]              nmn;
	logic                       s_lt;
	logic                       s_tie;

	logic                       div_start;
	logic [kce_pkg::DIV_W-1:0]  div_dividend;
	logic [kce_pkg::SPAN_W-1:0] div_divisor;
	logic [kce_pkg::DIV_KW-1:0] div_steps;
	logic                       div_busy;
	logic [kce_pkg::DIV_W-1:0]  div_quot;
	logic [kce_pkg::SPAN_W-1:0] div_rem;

	logic                       we;
	logic                       re;
	logic [AW-1:0]              waddr;
	logic [AW-1:0]              raddr;
	logic [CW-1:0]              wdata;
	logic [CW+15:0]             cnt_ext;
	logic [AW+15:0]             wit_ext;

	assign inc_sat = rdata_q == kce_pkg::COUNT_MAX;
	assign dec_sat = rdata_q == '0;
	assign nc_fwd  = inc_sat ? rdata_q : rdata_q + CW'(1);
	assign nc_bwd  = dec_sat ? rdata_q : rdata_q - CW'(1);
	assign f_gt    = nc_fwd > best_max_q;
	assign f_tie   = (nc_fwd == best_max_q) && (w_q < max_wit_q);
	assign nbm     = f_gt ? nc_fwd : best_max_q;
	assign nmw     = (f_gt || f_tie) ? w_q : max_wit_q;
	assign b_lt    = nc_bwd < best_min_q;
	assign b_tie   = (nc_bwd == best_min_q) && (w_q < min_wit_q);
	assign nbn     = b_lt ? nc_bwd : best_min_q;
	assign nmn     = (b_lt || b_tie) ? w_q : min_wit_q;
	assign s_lt    = rdata_q < scan_mn_q;
	assign s_tie   = (rdata_q == scan_mn_q) && (scan_addr_s1 < scan_wt_q);

	assign div_start = cmd.div_red | cmd.div_fwd | cmd.div_bwd;

	always_comb begin
		if (cmd.div_red) begin
			div_dividend = kce_pkg::DIV_W'(w_q);
		end else if (cmd.div_fwd) begin
			div_dividend = kce_pkg::DIV_W'(w_q) * kce_pkg::DIV_W'(cfg.base)
				+ kce_pkg::DIV_W'(digit_q);
		end else begin
			div_dividend = kce_pkg::DIV_W'(digit_q) * kce_pkg::DIV_W'(cfg.span)
				+ kce_pkg::DIV_W'(w_q);
		end
	end

	assign div_divisor = cmd.div_bwd ? kce_pkg::SPAN_W'(cfg.base) : cfg.span;
	assign div_steps   = cmd.div_fwd ? kce_pkg::DIV_KW'(kce_pkg::FWD_STEPS)
		: kce_pkg::DIV_KW'(AW);

	kce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign we    = cmd.clr_wr | cmd.upd_fwd | cmd.upd_bwd;
	assign re    = cmd.rd_win | cmd.scan_rd;
	assign waddr = cmd.clr_wr ? clr_q : w_q;
	assign raddr = cmd.scan_rd ? scan_q[AW-1:0] : w_q;
	assign wdata = cmd.clr_wr ? '0 : (cmd.upd_fwd ? nc_fwd : nc_bwd);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= '0;
			seen_q     <= '0;
			best_max_q <= '0;
			max_wit_q  <= '0;
			best_min_q <= '0;
			min_wit_q  <= '0;
		end else if (cmd.clr_regs) begin
			w_q        <= '0;
			seen_q     <= '0;
			best_max_q <= '0;
			max_wit_q  <= '0;
			best_min_q <= '0;
			min_wit_q  <= '0;
		end else begin
			if (cmd.take_red || cmd.take_fwd) begin
				w_q <= div_rem[AW-1:0];
			end else if (cmd.take_bwd) begin
				w_q <= div_quot[AW-1:0];
			end
			if (cmd.seen_inc) begin
				seen_q <= seen_q + kce_pkg::REG_W'(1);
			end else if (cmd.seen_full) begin
				seen_q <= cfg.length;
			end
			if (cmd.upd_fwd) begin
				best_max_q <= nbm;
				max_wit_q  <= nmw;
			end
			if (cmd.upd_bwd) begin
				best_min_q <= nbn;
				min_wit_q  <= nmn;
			end else if (cmd.scan_fin) begin
				best_min_q <= scan_mn_q;
				min_wit_q  <= scan_wt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			scan_q    <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			if (cmd.clr_init) begin
				clr_q <= '0;
			end else if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.scan_init) begin
				scan_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_q <= scan_q + kce_pkg::SPAN_W'(1);
			end
			scan_v_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q  <= in_mode;
			digit_q <= in_digit;
		end
		scan_addr_s1 <= scan_q[AW-1:0];
		if (cmd.scan_init) begin
			scan_mn_q <= best_max_q;
			scan_wt_q <= max_wit_q;
		end else if (scan_v_s1) begin
			if (s_lt || s_tie) begin
				scan_wt_q <= scan_addr_s1;
			end
			if (s_lt) begin
				scan_mn_q <= rdata_q;
			end
		end
		if (cmd.res_set) begin
			res_cnt_q <= '0;
			res_wit_q <= '0;
			res_st_q  <= cmd.res_st;
		end else if (cmd.upd_fwd) begin
			res_cnt_q <= nbm;
			res_wit_q <= nmw;
			res_st_q  <= inc_sat ? kce_pkg::ST_SAT : kce_pkg::ST_OK;
		end else if (cmd.upd_bwd) begin
			res_cnt_q <= nbn;
			res_wit_q <= nmn;
			res_st_q  <= dec_sat ? kce_pkg::ST_SAT : kce_pkg::ST_OK;
		end else if (cmd.scan_fin) begin
			res_cnt_q <= scan_mn_q;
			res_wit_q <= scan_wt_q;
			res_st_q  <= kce_pkg::ST_OK;
		end
		if (cmd.out_load) begin
			out_cnt_q <= cnt_ext[15:0];
			out_wit_q <= wit_ext[15:0];
			out_st_q  <= res_st_q;
		end
	end

	assign cnt_ext = {16'd0, res_cnt_q};
	assign wit_ext = {16'd0, res_wit_q};

	assign sts.mode           = mode_q;
	assign sts.digit_bad      = {1'b0, digit_q} >= cfg.base;
	assign sts.span_zero      = cfg.span == '0;
	assign sts.win_ge_span    = {1'b0, w_q} >= cfg.span;
	assign sts.seen_short_fwd = ({1'b0, seen_q} + 6'd1) < {1'b0, cfg.length};
	assign sts.seen_short_bwd = seen_q < cfg.length;
	assign sts.div_busy       = div_busy;
	assign sts.clr_last       = clr_q == AW'(kce_pkg::TABLE_DEPTH - 1);
	assign sts.scan_last      = scan_q == (cfg.span - kce_pkg::SPAN_W'(1));

	assign count_value = out_cnt_q;
	assign witness     = out_wit_q;
	assign status      = out_st_q;

endmodule
`default_nettype wire

// ----- rtl/kce_ctrl.sv -----
// Controller state machine sequencing table passes, divisions and result hand-off.
`default_nettype none
module kce_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire logic          span_busy,
	input  wire kce_pkg::sts_t sts,
	output kce_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_DECODE  = 4'd2;
	localparam logic [3:0] S_RWAIT   = 4'd3;
	localparam logic [3:0] S_DISP    = 4'd4;
	localparam logic [3:0] S_FWAIT   = 4'd5;
	localparam logic [3:0] S_FRD     = 4'd6;
	localparam logic [3:0] S_FUPD    = 4'd7;
	localparam logic [3:0] S_BRD     = 4'd8;
	localparam logic [3:0] S_BUPD    = 4'd9;
	localparam logic [3:0] S_BWAIT   = 4'd10;
	localparam logic [3:0] S_SCAN    = 4'd11;
	localparam logic [3:0] S_SCANEND = 4'd12;
	localparam logic [3:0] S_SCANFIN = 4'd13;
	localparam logic [3:0] S_EMIT    = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       clr_emit_q;
	logic       clr_emit_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && !span_busy;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		clr_emit_d = clr_emit_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = clr_emit_q ? S_EMIT : S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid && !span_busy) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.mode == kce_pkg::MODE_CLEAR) begin
					cmd.clr_regs = 1'b1;
					cmd.clr_init = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_st   = kce_pkg::ST_OK;
					clr_emit_d   = 1'b1;
					state_d      = S_CLEAR;
				end else if (sts.span_zero) begin
					cmd.res_set = 1'b1;
					cmd.res_st  = kce_pkg::ST_BAD_CFG;
					state_d     = S_EMIT;
				end else if (sts.win_ge_span) begin
					cmd.div_red = 1'b1;
					state_d     = S_RWAIT;
				end else begin
					state_d = S_DISP;
				end
			end
			S_RWAIT: begin
				if (!sts.div_busy) begin
					cmd.take_red = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.mode == kce_pkg::MODE_SCAN) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else if (sts.digit_bad) begin
					cmd.res_set = 1'b1;
					cmd.res_st  = kce_pkg::ST_BAD_DIGIT;
					state_d     = S_EMIT;
				end else if (sts.mode == kce_pkg::MODE_FWD) begin
					cmd.div_fwd = 1'b1;
					state_d     = S_FWAIT;
				end else if (sts.seen_short_bwd) begin
					cmd.res_set = 1'b1;
					cmd.res_st  = kce_pkg::ST_OK;
					state_d     = S_EMIT;
				end else begin
					state_d = S_BRD;
				end
			end
			S_FWAIT: begin
				if (!sts.div_busy) begin
					cmd.take_fwd = 1'b1;
					if (sts.seen_short_fwd) begin
						cmd.seen_inc = 1'b1;
						cmd.res_set  = 1'b1;
						cmd.res_st   = kce_pkg::ST_OK;
						state_d      = S_EMIT;
					end else begin
						cmd.seen_full = 1'b1;
						state_d       = S_FRD;
					end
				end
			end
			S_FRD: begin
				cmd.rd_win = 1'b1;
				state_d    = S_FUPD;
			end
			S_FUPD: begin
				cmd.upd_fwd = 1'b1;
				state_d     = S_EMIT;
			end
			S_BRD: begin
				cmd.rd_win = 1'b1;
				state_d    = S_BUPD;
			end
			S_BUPD: begin
				cmd.upd_bwd = 1'b1;
				cmd.div_bwd = 1'b1;
				state_d     = S_BWAIT;
			end
			S_BWAIT: begin
				if (!sts.div_busy) begin
					cmd.take_bwd = 1'b1;
					state_d      = S_EMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_SCANEND;
				end
			end
			S_SCANEND: begin
				state_d = S_SCANFIN;
			end
			S_SCANFIN: begin
				cmd.scan_fin = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_emit_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_emit_q <= clr_emit_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the k-gram window counter with running count extremes.
`timescale 1ns / 1ps
module testbench;

	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int HOLD_AT      = 600;
	localparam int HOLD_LEN     = 400;
	localparam int SETTLE_WAIT  = 40;
	localparam int NPHASES      = 10;

	localparam logic [2:0] ADDR_BASE = {kce_pkg::REG_BASE, 2'b00};
	localparam logic [2:0] ADDR_LEN  = {kce_pkg::REG_LEN, 2'b00};

	typedef struct packed {
		logic [15:0] count_value;
		logic [15:0] witness;
		logic [1:0]  status;
	} extreme_t;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [1:0] mode;
		logic [3:0] digit;
		logic [2:0] addr;
		logic [4:0] value;
		logic       known;
		extreme_t   answer;
	} plan_row_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [3:0] digit, [7:4] zero
	logic [1:0]  s_tuser  = '0;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [15:0] count_value, [31:16] witness
	logic [1:0]  m_tuser;         // [1:0] status
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	kgram_count_extremes i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// window histogram and running extremes as the block should hold them
	logic [15:0] hist [kce_pkg::TABLE_DEPTH];
	logic [4:0]  base_reg;
	logic [4:0]  len_reg;
	logic [16:0] span;
	logic [15:0] win;
	logic [4:0]  seen;
	logic [15:0] best_max;
	logic [15:0] max_wit;
	logic [15:0] best_min;
	logic [15:0] min_wit;

	extreme_t  expected_extremes [$];
	plan_row_t directed_plan [$];

	int send_idle    = 0;
	int recv_stall   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int scans_sent   = 0;
	int clears_sent  = 0;
	int reg_writes   = 0;
	int fail_count   = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	int cycle_count  = 0;

	int phase_base  [NPHASES] = '{2, 3, 16, 4, 2, 7, 31, 5, 16, 2};
	int phase_len   [NPHASES] = '{2, 3, 1, 4, 16, 2, 0, 3, 4, 1};
	int phase_items [NPHASES] = '{250, 250, 250, 250, 200, 250, 60, 250, 200, 150};

	function automatic logic [16:0] span_of(logic [4:0] a, logic [4:0] l);
		int unsigned p;
		p = 1;
		if (a < kce_pkg::BASE_MIN || a > kce_pkg::BASE_MAX
				|| l < kce_pkg::LEN_MIN || l > kce_pkg::LEN_MAX)
			return '0;
		for (int i = 0; i < l; i++) begin
			p = p * a;
			if (p > kce_pkg::TABLE_DEPTH)
				return '0;
		end
		return p[16:0];
	endfunction

	function automatic void wipe_history();
		for (int i = 0; i < kce_pkg::TABLE_DEPTH; i++)
			hist[i] = '0;
		win      = '0;
		seen     = '0;
		best_max = '0;
		max_wit  = '0;
		best_min = '0;
		min_wit  = '0;
	endfunction

	function automatic extreme_t predict_extremes(logic [1:0] m, logic [3:0] d);
		extreme_t    r;
		int unsigned idx;
		int unsigned cur;
		int unsigned mn;
		int unsigned wt;
		int unsigned c;
		logic [1:0]  st;
		r  = '0;
		st = kce_pkg::ST_OK;
		if (m == kce_pkg::MODE_CLEAR) begin
			wipe_history();
			return r;
		end
		if (span == 0) begin
			r.status = kce_pkg::ST_BAD_CFG;
			return r;
		end
		win = 16'(32'(win) % 32'(span));
		if (m == kce_pkg::MODE_SCAN) begin
			mn = best_max;
			wt = max_wit;
			for (int unsigned i = 0; i < span; i++) begin
				c = hist[i];
				if (c < mn || (c == mn && i < wt))
					wt = i;
				if (c < mn)
					mn = c;
			end
			best_min      = mn[15:0];
			min_wit       = wt[15:0];
			r.count_value = mn[15:0];
			r.witness     = wt[15:0];
			return r;
		end
		if (d >= base_reg) begin
			r.status = kce_pkg::ST_BAD_DIGIT;
			return r;
		end
		if (m == kce_pkg::MODE_FWD) begin
			win = 16'((32'(win) * 32'(base_reg) + 32'(d)) % 32'(span));
			if (32'(seen) + 1 < 32'(len_reg)) begin
				seen = seen + 5'd1;
				return r;
			end
			seen = len_reg;
			idx  = win;
			cur  = hist[idx];
			if (cur >= kce_pkg::COUNT_MAX)
				st = kce_pkg::ST_SAT;
			else
				cur++;
			hist[idx] = cur[15:0];
			if (cur > best_max) begin
				best_max = cur[15:0];
				max_wit  = idx[15:0];
			end
			if (cur == best_max && idx < max_wit)
				max_wit = idx[15:0];
			r.count_value = best_max;
			r.witness     = max_wit;
			r.status      = st;
			return r;
		end
		if (seen < len_reg)
			return r;
		idx = win;
		cur = hist[idx];
		if (cur == 0)
			st = kce_pkg::ST_SAT;
		else
			cur--;
		hist[idx] = cur[15:0];
		if (cur < best_min) begin
			best_min = cur[15:0];
			min_wit  = idx[15:0];
		end
		if (cur == best_min && idx < min_wit)
			min_wit = idx[15:0];
		r.count_value = best_min;
		r.witness     = min_wit;
		r.status      = st;
		win = 16'((32'(d) * 32'(span) + idx) / 32'(base_reg));
		return r;
	endfunction

	function automatic plan_row_t plan_item(logic [1:0] m, logic [3:0] d);
		plan_row_t r;
		r       = '0;
		r.kind  = ROW_ITEM;
		r.mode  = m;
		r.digit = d;
		return r;
	endfunction

	function automatic plan_row_t plan_known(logic [1:0] m, logic [3:0] d,
			logic [15:0] c, logic [15:0] w, logic [1:0] st);
		plan_row_t r;
		r                    = plan_item(m, d);
		r.known              = 1'b1;
		r.answer.count_value = c;
		r.answer.witness     = w;
		r.answer.status      = st;
		return r;
	endfunction

	function automatic plan_row_t plan_write(logic [2:0] a, logic [4:0] v);
		plan_row_t r;
		r       = '0;
		r.kind  = ROW_WRITE;
		r.addr  = a;
		r.value = v;
		return r;
	endfunction

	task automatic send_item(logic [1:0] m, logic [3:0] d, logic known, extreme_t typed);
		extreme_t predicted;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= {4'b0, d};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_extremes(m, d);
		expected_extremes.push_back(known ? typed : predicted);
		items_sent++;
		if (m == kce_pkg::MODE_SCAN)
			scans_sent++;
		if (m == kce_pkg::MODE_CLEAR)
			clears_sent++;
	endtask

	// drop valid and hold until every result is back and the block is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_extremes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] a, logic [4:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= {27'b0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (a == ADDR_BASE)
			base_reg = v;
		else
			len_reg = v;
		span = span_of(base_reg, len_reg);
		reg_writes++;
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {27'b0, v}) begin
			$error("register readback at %0d: expected %0d, got %0d", a, v, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!hold_done && items_sent >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		extreme_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_extremes.size() == 0) begin
				$error("result with none pending: count_value %0d witness %0d status %0d",
					m_tdata[15:0], m_tdata[31:16], m_tuser);
				fail_count++;
			end else begin
				want = expected_extremes.pop_front();
				results_seen++;
				if (m_tdata[15:0] !== want.count_value) begin
					$error("count_value: expected %0d, got %0d", want.count_value,
						m_tdata[15:0]);
					fail_count++;
				end
				if (m_tdata[31:16] !== want.witness) begin
					$error("witness: expected %0d, got %0d", want.witness, m_tdata[31:16]);
					fail_count++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					fail_count++;
				end
			end
		end
	end

	initial begin
		logic [1:0]  m;
		logic [3:0]  d;
		int unsigned roll;
		int          clears_left;
		int          big_scans_left;
		plan_row_t   row;

		clears_left    = 3;
		big_scans_left = 3;
		base_reg       = kce_pkg::BASE_RST;
		len_reg        = kce_pkg::LEN_RST;
		span           = span_of(base_reg, len_reg);
		wipe_history();

		directed_plan.push_back(plan_known(kce_pkg::MODE_FWD, 4'd1, 16'd1, 16'd1,
			kce_pkg::ST_OK));
		directed_plan.push_back(plan_known(kce_pkg::MODE_FWD, 4'd2, 16'd0, 16'd0,
			kce_pkg::ST_BAD_DIGIT));
		directed_plan.push_back(plan_known(kce_pkg::MODE_FWD, 4'd15, 16'd0, 16'd0,
			kce_pkg::ST_BAD_DIGIT));
		directed_plan.push_back(plan_item(kce_pkg::MODE_BWD, 4'd0));
		directed_plan.push_back(plan_known(kce_pkg::MODE_BWD, 4'd1, 16'd0, 16'd0,
			kce_pkg::ST_SAT));
		directed_plan.push_back(plan_item(kce_pkg::MODE_SCAN, 4'd0));
		directed_plan.push_back(plan_known(kce_pkg::MODE_CLEAR, 4'd15, 16'd0, 16'd0,
			kce_pkg::ST_OK));
		directed_plan.push_back(plan_known(kce_pkg::MODE_BWD, 4'd0, 16'd0, 16'd0,
			kce_pkg::ST_OK));
		directed_plan.push_back(plan_write(ADDR_LEN, 5'd3));
		directed_plan.push_back(plan_write(ADDR_BASE, 5'd3));
		directed_plan.push_back(plan_known(kce_pkg::MODE_FWD, 4'd2, 16'd0, 16'd0,
			kce_pkg::ST_OK));
		directed_plan.push_back(plan_known(kce_pkg::MODE_FWD, 4'd0, 16'd0, 16'd0,
			kce_pkg::ST_OK));
		directed_plan.push_back(plan_item(kce_pkg::MODE_FWD, 4'd1));
		directed_plan.push_back(plan_item(kce_pkg::MODE_FWD, 4'd2));
		directed_plan.push_back(plan_item(kce_pkg::MODE_BWD, 4'd2));
		directed_plan.push_back(plan_item(kce_pkg::MODE_SCAN, 4'd0));
		directed_plan.push_back(plan_known(kce_pkg::MODE_BWD, 4'd3, 16'd0, 16'd0,
			kce_pkg::ST_BAD_DIGIT));
		directed_plan.push_back(plan_write(ADDR_BASE, 5'd16));
		directed_plan.push_back(plan_write(ADDR_LEN, 5'd4));
		directed_plan.push_back(plan_item(kce_pkg::MODE_FWD, 4'd15));
		directed_plan.push_back(plan_item(kce_pkg::MODE_FWD, 4'd0));
		directed_plan.push_back(plan_item(kce_pkg::MODE_FWD, 4'd15));
		directed_plan.push_back(plan_item(kce_pkg::MODE_FWD, 4'd15));
		directed_plan.push_back(plan_item(kce_pkg::MODE_BWD, 4'd15));
		directed_plan.push_back(plan_write(ADDR_LEN, 5'd5));
		directed_plan.push_back(plan_known(kce_pkg::MODE_FWD, 4'd1, 16'd0, 16'd0,
			kce_pkg::ST_BAD_CFG));
		directed_plan.push_back(plan_known(kce_pkg::MODE_SCAN, 4'd0, 16'd0, 16'd0,
			kce_pkg::ST_BAD_CFG));
		directed_plan.push_back(plan_known(kce_pkg::MODE_BWD, 4'd0, 16'd0, 16'd0,
			kce_pkg::ST_BAD_CFG));
		directed_plan.push_back(plan_write(ADDR_BASE, 5'd1));
		directed_plan.push_back(plan_write(ADDR_LEN, 5'd16));
		directed_plan.push_back(plan_known(kce_pkg::MODE_FWD, 4'd0, 16'd0, 16'd0,
			kce_pkg::ST_BAD_CFG));
		directed_plan.push_back(plan_write(ADDR_BASE, 5'd2));
		directed_plan.push_back(plan_item(kce_pkg::MODE_FWD, 4'd1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				cfg_write(row.addr, row.value);
			end else begin
				send_item(row.mode, row.digit, row.known, row.answer);
			end
		end

		for (int p = 0; p < NPHASES; p++) begin
			settle();
			cfg_write(ADDR_BASE, 5'(phase_base[p]));
			cfg_write(ADDR_LEN, 5'(phase_len[p]));
			case (p % 4)
				0: begin
					send_idle  = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle  = 46;
					recv_stall = 0;
				end
				2: begin
					send_idle  = 0;
					recv_stall = 46;
				end
				default: begin
					send_idle  = 8;
					recv_stall = 8;
				end
			endcase
			for (int n = 0; n < phase_items[p]; n++) begin
				if (p == 5 && n == 120)
					settle();
				roll = $urandom_range(999);
				if (roll < 5 && clears_left > 0) begin
					m = kce_pkg::MODE_CLEAR;
					clears_left--;
				end else if (roll < 80 && (span <= 1024 || big_scans_left > 0)) begin
					m = kce_pkg::MODE_SCAN;
					if (span > 1024)
						big_scans_left--;
				end else if (roll < 400) begin
					m = kce_pkg::MODE_BWD;
				end else begin
					m = kce_pkg::MODE_FWD;
				end
				if (base_reg >= kce_pkg::BASE_MIN && base_reg <= kce_pkg::BASE_MAX
						&& $urandom_range(9) != 0)
					d = 4'($urandom_range(base_reg - 5'd1));
				else
					d = 4'($urandom_range(15));
				send_item(m, d, 1'b0, '0);
			end
		end

		settle();
		$display("covered %0d items (%0d scans, %0d clears) across %0d register writes",
			items_sent, scans_sent, clears_sent, reg_writes);
		$display("checked %0d results, %0d mismatches", results_seen, fail_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
